>>> sv/rgbhsl_pkg.sv
// Shared types, constants and the divider step for the RGB to HSL converter.
package rgbhsl_pkg;

   localparam int unsigned NumCells = 10;
   localparam int unsigned LaneWidth = 10;

   localparam logic [13:0] FullTurn = 14'd5760;
   localparam logic [12:0] GreenOffset = 13'd1920;
   localparam logic [12:0] BlueOffset = 13'd3840;
   localparam logic [18:0] SatScale = 19'd510;
   localparam logic [18:0] HueScale = 19'd1920;
   localparam logic [8:0] ChannelFull = 9'd255;
   localparam logic [8:0] DoubleFull = 9'd510;

   typedef struct packed {
      logic [LaneWidth-1:0] rem;
      logic [LaneWidth-1:0] low;
      logic [LaneWidth-1:0] den;
      logic [LaneWidth-1:0] quot;
   } div_lane_type;

   typedef struct packed {
      div_lane_type hue_lane;
      div_lane_type sat_lane;
      logic [12:0] offset;
      logic neg;
      logic gray;
      logic [8:0] lsum;
   } div_work_type;

   function automatic div_lane_type div_step(input div_lane_type lane);
      div_lane_type res;
      logic [LaneWidth-1:0] shifted;
      logic take;
      shifted = {lane.rem[LaneWidth-2:0], lane.low[LaneWidth-1]};
      take = (shifted >= lane.den);
      res.rem = take ? (shifted - lane.den) : shifted;
      res.low = {lane.low[LaneWidth-2:0], 1'b0};
      res.den = lane.den;
      res.quot = {lane.quot[LaneWidth-2:0], take};
      return res;
   endfunction

endpackage

>>> sv/rgbhsl_if.sv
// Request and response channel interfaces of the RGB to HSL converter.
interface rgbhsl_req_if;
   logic valid;
   logic ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbhsl_rsp_if;
   logic valid;
   logic ready;
   logic [12:0] hue_sixteenths;
   logic [7:0] saturation;
   logic [8:0] lightness_sum;
   modport source (output valid, hue_sixteenths, saturation, lightness_sum, input ready);
   modport sink (input valid, hue_sixteenths, saturation, lightness_sum, output ready);
endinterface

>>> sv/rgbhsl_front.sv
// Front stage: finds max, min and sector, and sets up both divisions.
module rgbhsl_front
   import rgbhsl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   rgbhsl_req_if.sink   req,
   output logic         out_valid,
   input  logic         out_ready,
   output div_work_type out_work
);

   logic valid_ff;
   div_work_type work_ff;
   div_work_type work_in;
   logic red_max, green_max;
   logic [7:0] mx, mn, delta, pos, neg, diff, den_s;
   logic [8:0] lsum, den_wide;
   logic [18:0] sat_n, hue_n;

   assign req.ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work = work_ff;

   always_comb begin
      red_max = (req.red >= req.green) && (req.red >= req.blue);
      green_max = !red_max && (req.green >= req.blue);
      mx = red_max ? req.red : (green_max ? req.green : req.blue);
      mn = req.red;
      if (req.green < mn) begin
         mn = req.green;
      end
      if (req.blue < mn) begin
         mn = req.blue;
      end
      delta = mx - mn;
      lsum = {1'b0, mx} + {1'b0, mn};
      den_wide = (lsum <= ChannelFull) ? lsum : (DoubleFull - lsum);
      den_s = den_wide[7:0];
      if (red_max) begin
         pos = req.green;
         neg = req.blue;
         work_in.offset = '0;
      end else if (green_max) begin
         pos = req.blue;
         neg = req.red;
         work_in.offset = GreenOffset;
      end else begin
         pos = req.red;
         neg = req.green;
         work_in.offset = BlueOffset;
      end
      diff = (pos >= neg) ? (pos - neg) : (neg - pos);
      sat_n = 19'(delta) * SatScale + 19'(den_s);
      hue_n = 19'(diff) * HueScale + 19'(delta);
      work_in.sat_lane.rem = 10'(sat_n[18:10]);
      work_in.sat_lane.low = sat_n[9:0];
      work_in.sat_lane.den = 10'({den_s, 1'b0});
      work_in.sat_lane.quot = '0;
      work_in.hue_lane.rem = 10'(hue_n[18:10]);
      work_in.hue_lane.low = hue_n[9:0];
      work_in.hue_lane.den = 10'({delta, 1'b0});
      work_in.hue_lane.quot = '0;
      work_in.neg = (pos < neg);
      work_in.gray = (delta == 8'd0);
      work_in.lsum = lsum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         work_ff <= work_in;
      end
   end

endmodule

>>> sv/rgbhsl_div_cell.sv
// Divider cell: one quotient bit of the hue and saturation divisions.
module rgbhsl_div_cell
   import rgbhsl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_work_type in_work,
   output logic         out_valid,
   input  logic         out_ready,
   output div_work_type out_work
);

   logic valid_ff;
   div_work_type work_ff;
   div_work_type work_in;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work = work_ff;

   always_comb begin
      work_in = in_work;
      work_in.hue_lane = div_step(in_work.hue_lane);
      work_in.sat_lane = div_step(in_work.sat_lane);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule

>>> sv/rgbhsl_back.sv
// Back stage: applies the hue sector offset and wrap, and holds the response.
module rgbhsl_back
   import rgbhsl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_work_type in_work,
   rgbhsl_rsp_if.source rsp
);

   logic valid_ff;
   logic [12:0] hue_ff, hue_in;
   logic [7:0] sat_ff, sat_in;
   logic [8:0] lsum_ff;
   logic [13:0] raw, wrapped;

   assign in_ready = !valid_ff || rsp.ready;
   assign rsp.valid = valid_ff;
   assign rsp.hue_sixteenths = hue_ff;
   assign rsp.saturation = sat_ff;
   assign rsp.lightness_sum = lsum_ff;

   always_comb begin
      if (in_work.neg) begin
         raw = 14'(in_work.offset) + FullTurn - 14'(in_work.hue_lane.quot);
      end else begin
         raw = 14'(in_work.offset) + 14'(in_work.hue_lane.quot);
      end
      wrapped = (raw >= FullTurn) ? (raw - FullTurn) : raw;
      hue_in = in_work.gray ? 13'd0 : wrapped[12:0];
      sat_in = in_work.gray ? 8'd0 : in_work.sat_lane.quot[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         lsum_ff <= in_work.lsum;
      end
   end

endmodule

>>> sv/rgb_to_hsl_convert.sv
// Top level of the pipelined RGB to HSL converter.
// One pixel may be accepted every clock while responses are taken; each request passes in turn
// through the front stage, a row of ten divider cells that each settle one quotient bit of
// the hue and saturation divisions, and the response register, and the pipeline stalls stage
// by stage while the response is not taken.
module rgb_to_hsl_convert
   import rgbhsl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   rgbhsl_req_if.sink   req,
   rgbhsl_rsp_if.source rsp
);

   logic         valid_w [NumCells+1];
   logic         ready_w [NumCells+1];
   div_work_type work_w  [NumCells+1];

   rgbhsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_work  (work_w[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      rgbhsl_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_ready  (ready_w[i]),
         .in_work   (work_w[i]),
         .out_valid (valid_w[i+1]),
         .out_ready (ready_w[i+1]),
         .out_work  (work_w[i+1])
      );
   end

   rgbhsl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_w[NumCells]),
      .in_ready (ready_w[NumCells]),
      .in_work  (work_w[NumCells]),
      .rsp      (rsp)
   );

`ifndef ASSERT_OFF
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.hue_sixteenths < 13'd5760))
      else $error("hue out of range");

   a_black_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.lightness_sum == 9'd0)) |->
      ((rsp.hue_sixteenths == 13'd0) && (rsp.saturation == 8'd0)))
      else $error("black pixel gave nonzero hue or saturation");

   a_white_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.lightness_sum == 9'd510)) |->
      ((rsp.hue_sixteenths == 13'd0) && (rsp.saturation == 8'd0)))
      else $error("white pixel gave nonzero hue or saturation");

   a_last_cell_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_w[NumCells] && !ready_w[NumCells]) |=> valid_w[NumCells])
      else $error("last divider cell dropped a request");
`endif

endmodule
